// ===== sv/wbps_pkg.sv =====
// Shared types, codes and constants of the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int PATTERN_MAX_DEF = 1024;

   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_DATA    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
      logic       wildcard_req;
      logic       first;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] match_offset;
   } rsp_type;

   typedef struct packed {
      logic       pat_write;
      logic       data_take;
      logic       scan_step;
      logic       scan_stop;
      logic       emit;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic take_skip;
      logic take_empty;
      logic take_cmp;
      logic take_last;
      logic scan_end;
      logic scan_hit;
      logic last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/wbps_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module wbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wbps_datapath.sv =====
// Datapath of the scanner: pattern and window memories, counters, compare and result register.
module wbps_datapath #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  wbps_pkg::req_type  req_data,
   input  wbps_pkg::cmd_type  cmd,
   output wbps_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wbps_pkg::rsp_type  rsp_data
);
   import wbps_pkg::*;

   localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int SW = LW + 1;

   logic [LW-1:0] len_ff, len_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [31:0]   seen_ff, seen_in;
   logic          done_ff, done_in;
   logic          last_ff, last_in;
   logic          issue_ff, issue_in;
   logic [IW-1:0] rd_pi_ff, rd_pi_in;
   logic [IW-1:0] rd_slot_ff, rd_slot_in;
   logic          dval_ff, dval_in;
   logic          dfin_ff, dfin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [LW-1:0] len_eff_pat;
   logic          pat_we;
   logic          win_we;
   logic          done_eff;
   logic [IW-1:0] ptr_eff;
   logic [IW-1:0] ptr_next;
   logic [LW-1:0] fill_eff;
   logic [LW-1:0] fill_new;
   logic [31:0]   seen_eff;
   logic          need_cmp;
   logic [SW-1:0] start_sum;
   logic [SW-1:0] start_mod;
   logic          pi_final;
   logic          match_now;
   logic [8:0]    pat_rd;
   logic [7:0]    win_rd;

   wbps_ram #(.WIDTH(9), .DEPTH(PATTERN_MAX)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (len_eff_pat[IW-1:0]),
      .wr_data ({req_data.wildcard_req, req_data.byte_value}),
      .rd_addr (rd_pi_ff),
      .rd_data (pat_rd)
   );

   wbps_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_window_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (ptr_eff),
      .wr_data (req_data.byte_value),
      .rd_addr (rd_slot_ff),
      .rd_data (win_rd)
   );

   always_comb begin
      len_eff_pat = req_data.first ? '0 : len_ff;
      done_eff    = req_data.first ? 1'b0 : done_ff;
      ptr_eff     = req_data.first ? '0 : ptr_ff;
      fill_eff    = req_data.first ? '0 : fill_ff;
      seen_eff    = req_data.first ? '0 : seen_ff;
      ptr_next    = (ptr_eff == IW'(PATTERN_MAX - 1)) ? '0 : ptr_eff + IW'(1);
      fill_new    = (fill_eff == LW'(PATTERN_MAX)) ? fill_eff : fill_eff + LW'(1);
      need_cmp    = (fill_new >= len_ff);
      start_sum   = SW'(ptr_eff) + SW'(PATTERN_MAX) - SW'(len_ff) + SW'(1);
      start_mod   = (start_sum >= SW'(PATTERN_MAX)) ? start_sum - SW'(PATTERN_MAX) : start_sum;
      pi_final    = (LW'(rd_pi_ff) == len_ff - LW'(1));
      match_now   = pat_rd[8] || (pat_rd[7:0] == win_rd);
   end

   always_comb begin
      stat.take_skip  = done_eff;
      stat.take_empty = !done_eff && (len_ff == '0);
      stat.take_cmp   = !done_eff && (len_ff != '0) && need_cmp;
      stat.take_last  = req_data.last;
      stat.scan_end   = dval_ff && (!match_now || dfin_ff);
      stat.scan_hit   = match_now;
      stat.last       = last_ff;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      rd_pi_in     = rd_pi_ff;
      rd_slot_in   = rd_slot_ff;
      dval_in      = dval_ff;
      dfin_in      = dfin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pat_we       = 1'b0;
      win_we       = 1'b0;

      if (cmd.pat_write) begin
         if (len_eff_pat < LW'(PATTERN_MAX)) begin
            pat_we = 1'b1;
            len_in = len_eff_pat + LW'(1);
         end else begin
            len_in = len_eff_pat;
         end
         seen_in  = '0;
         ptr_in   = '0;
         fill_in  = '0;
         done_in  = 1'b0;
         issue_in = 1'b0;
         dval_in  = 1'b0;
      end

      if (cmd.data_take) begin
         ptr_in  = ptr_eff;
         fill_in = fill_eff;
         seen_in = seen_eff;
         done_in = done_eff;
         dval_in = 1'b0;
         if (!done_eff && (len_ff != '0)) begin
            win_we     = 1'b1;
            ptr_in     = ptr_next;
            fill_in    = fill_new;
            last_in    = req_data.last;
            rd_pi_in   = '0;
            rd_slot_in = start_mod[IW-1:0];
            issue_in   = need_cmp;
            if (!need_cmp) begin
               seen_in = seen_eff + 32'd1;
            end
         end
      end

      if (cmd.scan_step) begin
         dval_in = issue_ff;
         dfin_in = issue_ff && pi_final;
         if (issue_ff) begin
            if (pi_final) begin
               issue_in = 1'b0;
            end else begin
               rd_pi_in   = rd_pi_ff + IW'(1);
               rd_slot_in = (rd_slot_ff == IW'(PATTERN_MAX - 1)) ? '0 : rd_slot_ff + IW'(1);
            end
         end
      end

      if (cmd.scan_stop) begin
         issue_in = 1'b0;
         dval_in  = 1'b0;
         seen_in  = seen_ff + 32'd1;
      end

      if (cmd.emit) begin
         done_in             = 1'b1;
         rsp_valid_in        = 1'b1;
         rsp_data_in.status  = cmd.code;
         rsp_data_in.match_offset = (cmd.code == STATUS_FOUND) ? seen_ff - 32'(len_ff) : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         seen_ff      <= '0;
         done_ff      <= 1'b0;
         issue_ff     <= 1'b0;
         dval_ff      <= 1'b0;
         dfin_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         done_ff      <= done_in;
         issue_ff     <= issue_in;
         dval_ff      <= dval_in;
         dfin_ff      <= dfin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      rd_pi_ff    <= rd_pi_in;
      rd_slot_ff  <= rd_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/wbps_ctrl.sv =====
// Controller state machine of the scanner: request intake, compare loop and result handoff.
module wbps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  wbps_pkg::stat_type  stat,
   output wbps_pkg::cmd_type   cmd
);
   import wbps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       take;

   always_comb begin
      take      = req_valid && (state_ff == ST_IDLE);
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_mode == MODE_PATTERN) begin
                  cmd.pat_write = 1'b1;
               end else begin
                  cmd.data_take = 1'b1;
                  if (stat.take_skip) begin
                     state_in = ST_IDLE;
                  end else if (stat.take_empty) begin
                     code_in  = STATUS_EMPTY;
                     state_in = ST_EMIT;
                  end else if (stat.take_cmp) begin
                     state_in = ST_SCAN;
                  end else if (stat.take_last) begin
                     code_in  = STATUS_NONE;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) begin
               cmd.scan_stop = 1'b1;
               if (stat.scan_hit) begin
                  code_in  = STATUS_FOUND;
                  state_in = ST_EMIT;
               end else if (stat.last) begin
                  code_in  = STATUS_NONE;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner.
// A pattern element or a data byte that completes no window is taken in the idle state and needs no compare loop.
// A data byte that completes a window runs a compare loop of one pattern element per
// cycle over the pattern and window memory read ports, ending at the first mismatch or after the last element.
// A result passes through the handoff state and then waits in the output register while rsp_stall is high.
// Synchronous reset clears the pattern length, scan counters and handshakes; no clearing pass.
module wildcard_byte_pattern_scanner #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wbps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wbps_pkg::rsp_type rsp_data
);
   import wbps_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   wbps_datapath #(.PATTERN_MAX(PATTERN_MAX)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
